### design/gbem_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gbem_pkg;

   // Field widths
   localparam int LABEL_W = 7;
   localparam int COORD_W = 4;
   localparam int SIZE_W  = 5;
   localparam int MODE_W  = 2;
   localparam int FACES   = 6;
   localparam int CLASS_W = 8;
   localparam int STEP_W  = 3;
   localparam int FACE_W  = 3;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 6;

   // Request kinds
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_READ  = 1'b1;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_SIZE_X   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SIZE_Y   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SIZE_Z   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MODE     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_NEUMANN  = 3'd4;

   // Reset values of the configuration registers
   localparam logic [SIZE_W-1:0] SIZE_RST    = 5'd16;
   localparam logic [MODE_W-1:0] MODE_RST    = 2'd2;
   localparam logic [FACES-1:0]  NEUMANN_RST = 6'h3f;

   // Grid modes
   localparam logic [MODE_W-1:0] MODE_1D = 2'd0;
   localparam logic [MODE_W-1:0] MODE_2D = 2'd1;
   localparam logic [MODE_W-1:0] MODE_3D = 2'd2;

   // Face codes, in priority order
   localparam logic [FACE_W-1:0] FACE_XMIN = 3'd0;
   localparam logic [FACE_W-1:0] FACE_XMAX = 3'd1;
   localparam logic [FACE_W-1:0] FACE_YMIN = 3'd2;
   localparam logic [FACE_W-1:0] FACE_YMAX = 3'd3;
   localparam logic [FACE_W-1:0] FACE_ZMIN = 3'd4;
   localparam logic [FACE_W-1:0] FACE_ZMAX = 3'd5;
   localparam logic [FACE_W-1:0] FACE_NONE = 3'd7;

   // Smallest solid number
   localparam logic [LABEL_W-1:0] SOLID_MIN = 7'd7;

   // Memory access steps of one read
   localparam logic [STEP_W-1:0] STEP_CENTER = 3'd0;
   localparam logic [STEP_W-1:0] STEP_XM     = 3'd1;
   localparam logic [STEP_W-1:0] STEP_XP     = 3'd2;
   localparam logic [STEP_W-1:0] STEP_YM     = 3'd3;
   localparam logic [STEP_W-1:0] STEP_YP     = 3'd4;
   localparam logic [STEP_W-1:0] STEP_ZM     = 3'd5;
   localparam logic [STEP_W-1:0] STEP_ZP     = 3'd6;
   localparam logic [STEP_W-1:0] STEP_LAST   = 3'd7;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_FINISH
   } state_type;

   // Side information of one memory read, valid with its data
   typedef struct packed {
      logic              in_mem;
      logic              open_nb;
      logic [FACE_W-1:0] face;
   } meta_type;

endpackage

`default_nettype wire

### design/gbem_label_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module gbem_label_ram #(
   parameter int DEPTH  = 4096,
   parameter int ADDR_W = 12
) (
   input  wire                          clock,
   input  wire                          wr_en,
   input  wire  [ADDR_W-1:0]            wr_addr,
   input  wire  [gbem_pkg::LABEL_W-1:0] wr_data,
   input  wire  [ADDR_W-1:0]            rd_addr,
   output logic [gbem_pkg::LABEL_W-1:0] rd_data
);
   import gbem_pkg::*;

   logic [LABEL_W-1:0] mem [DEPTH];

   // single write port, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

### design/grid_boundary_edge_marker.sv
`timescale 1ns / 1ps
`default_nettype none

// Grid boundary edge marker. Raw node labels (0 vacuum, 7..127 solid) are
// kept in one synchronous label memory; a write request (tuser 0) stores a
// label and gives no response, a write outside the grid in use is dropped.
// A read request (tuser 1) returns the node's final class: a face mark for
// vacuum on an active face, the negated solid number for a solid next to
// unmarked vacuum or a Neumann mark. A read reads the node and its six
// neighbours one after another through the memory's single read port, so
// it holds the block until its response is registered, and the next
// request is taken in the cycle after that. A read outside the grid skips
// the neighbour reads and answers with position_error set. The memory has no
// reset: a node must be written before it is read. The user must write
// configuration only while no request is in flight; the block does not check.
module grid_boundary_edge_marker #(
   parameter int MAX_NODES = 4096,
   parameter int MAX_DIM   = 16
) (
   input  wire                              clock,
   input  wire                              reset,
   // request channel
   input  wire                              req_tvalid,
   output logic                             req_tready,
   input  wire  [23:0]                      req_tdata,  // x_pos, y_pos, z_pos, raw_label
   input  wire                              req_tuser,  // op
   // response channel
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   output logic [7:0]                       rsp_tdata,  // node_class
   output logic                             rsp_tuser,  // position_error
   // configuration
   input  wire                              csr_we,
   input  wire  [gbem_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire  [gbem_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import gbem_pkg::*;

   localparam int ADDR_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int SPAN_W = $clog2(32 * MAX_DIM * MAX_DIM);
   localparam int FULL_W = (SPAN_W > ADDR_W) ? SPAN_W : ADDR_W;
   localparam logic [FULL_W-1:0] DIM_F = FULL_W'(MAX_DIM);

   // Configuration registers
   logic [SIZE_W-1:0] size_x_ff, size_y_ff, size_z_ff;
   logic [MODE_W-1:0] mode_ff;
   logic [FACES-1:0]  neumann_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff  <= SIZE_RST;
         size_y_ff  <= SIZE_RST;
         size_z_ff  <= SIZE_RST;
         mode_ff    <= MODE_RST;
         neumann_ff <= NEUMANN_RST;
      end else if (csr_we) begin
         case (csr_index)
            REG_SIZE_X:  size_x_ff  <= csr_wdata[SIZE_W-1:0];
            REG_SIZE_Y:  size_y_ff  <= csr_wdata[SIZE_W-1:0];
            REG_SIZE_Z:  size_z_ff  <= csr_wdata[SIZE_W-1:0];
            REG_MODE:    mode_ff    <= csr_wdata[MODE_W-1:0];
            REG_NEUMANN: neumann_ff <= csr_wdata[FACES-1:0];
            default: ;
         endcase
      end
   end

   // Extents in use, clamped to the grid capacity
   logic [SIZE_W-1:0] ext_x, ext_y, ext_z;
   assign ext_x = (int'(size_x_ff) > MAX_DIM) ? SIZE_W'(MAX_DIM) : size_x_ff;
   assign ext_y = (int'(size_y_ff) > MAX_DIM) ? SIZE_W'(MAX_DIM) : size_y_ff;
   assign ext_z = (int'(size_z_ff) > MAX_DIM) ? SIZE_W'(MAX_DIM) : size_z_ff;

   // First active face of an in-grid node
   function automatic logic [FACE_W-1:0] first_face(
      input logic [SIZE_W-1:0] px, py, pz,
      input logic [SIZE_W-1:0] ex, ey, ez,
      input logic [MODE_W-1:0] md
   );
      logic [FACE_W-1:0] f;
      f = FACE_NONE;
      if (px == '0) begin
         f = FACE_XMIN;
      end else if (SIZE_W'(px + 1'b1) == ex) begin
         f = FACE_XMAX;
      end else if (md >= MODE_2D && py == '0) begin
         f = FACE_YMIN;
      end else if (md >= MODE_2D && SIZE_W'(py + 1'b1) == ey) begin
         f = FACE_YMAX;
      end else if (md >= MODE_3D && pz == '0) begin
         f = FACE_ZMIN;
      end else if (md >= MODE_3D && SIZE_W'(pz + 1'b1) == ez) begin
         f = FACE_ZMAX;
      end
      return f;
   endfunction

   function automatic logic [FULL_W-1:0] node_addr(
      input logic [SIZE_W-1:0] px, py, pz
   );
      return ((FULL_W'(pz) * DIM_F) + FULL_W'(py)) * DIM_F + FULL_W'(px);
   endfunction

   // Request fields
   logic [COORD_W-1:0] req_x, req_y, req_z;
   logic [LABEL_W-1:0] req_label;
   assign req_x     = req_tdata[3:0];
   assign req_y     = req_tdata[7:4];
   assign req_z     = req_tdata[11:8];
   assign req_label = req_tdata[18:12];

   logic [FULL_W-1:0] req_full;
   logic              req_ok;
   logic              req_acc;
   assign req_full = node_addr(SIZE_W'(req_x), SIZE_W'(req_y), SIZE_W'(req_z));
   assign req_ok   = (SIZE_W'(req_x) < ext_x) && (SIZE_W'(req_y) < ext_y)
                     && (SIZE_W'(req_z) < ext_z);
   assign req_acc  = req_tvalid && req_tready;

   // Sequencer registers
   state_type          state_ff, state_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [COORD_W-1:0] cx_ff, cy_ff, cz_ff;
   meta_type           meta_ff, meta_in;
   logic [LABEL_W-1:0] center_ff, center_in;
   logic [FACE_W-1:0]  cface_ff, cface_in;
   logic               edge_ff, edge_in;
   logic [CLASS_W-1:0] res_class_ff, res_class_in;
   logic               res_err_ff, res_err_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CLASS_W-1:0] rsp_class_ff;
   logic               rsp_err_ff;
   logic               rsp_load;

   // Memory interface
   logic               wr_en;
   logic [ADDR_W-1:0]  rd_addr;
   logic [LABEL_W-1:0] rd_data;

   assign wr_en = req_acc && (req_tuser == OP_WRITE) && req_ok
                  && (int'(req_full) < MAX_NODES);

   gbem_label_ram #(
      .DEPTH  (MAX_NODES),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (req_full[ADDR_W-1:0]),
      .wr_data (req_label),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Node visited at the current step
   logic [SIZE_W-1:0] nx, ny, nz;
   logic              n_neg;
   logic              n_grid;
   logic [FULL_W-1:0] n_full;
   logic [FACE_W-1:0] n_face;

   always_comb begin
      nx    = SIZE_W'(cx_ff);
      ny    = SIZE_W'(cy_ff);
      nz    = SIZE_W'(cz_ff);
      n_neg = 1'b0;
      case (step_ff)
         STEP_XM: begin
            n_neg = (cx_ff == '0);
            nx    = SIZE_W'(cx_ff) - 1'b1;
         end
         STEP_XP: nx = SIZE_W'(cx_ff) + 1'b1;
         STEP_YM: begin
            n_neg = (cy_ff == '0);
            ny    = SIZE_W'(cy_ff) - 1'b1;
         end
         STEP_YP: ny = SIZE_W'(cy_ff) + 1'b1;
         STEP_ZM: begin
            n_neg = (cz_ff == '0);
            nz    = SIZE_W'(cz_ff) - 1'b1;
         end
         STEP_ZP: nz = SIZE_W'(cz_ff) + 1'b1;
         default: ;
      endcase
   end

   assign n_grid  = !n_neg && (nx < ext_x) && (ny < ext_y) && (nz < ext_z);
   assign n_full  = node_addr(nx, ny, nz);
   assign n_face  = first_face(nx, ny, nz, ext_x, ext_y, ext_z, mode_ff);
   assign rd_addr = n_full[ADDR_W-1:0];

   // Label just read, zero beyond the memory
   logic [LABEL_W-1:0] lab_now;
   logic               nb_open;
   logic               edge_all;
   assign lab_now  = meta_ff.in_mem ? rd_data : '0;
   assign nb_open  = meta_ff.open_nb && (lab_now == '0);
   assign edge_all = edge_ff || nb_open;

   // Next state and datapath
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      center_in    = center_ff;
      cface_in     = cface_ff;
      edge_in      = edge_ff;
      res_class_in = res_class_ff;
      res_err_in   = res_err_ff;
      req_tready   = 1'b0;
      rsp_load     = 1'b0;

      meta_in.in_mem  = n_grid && (int'(n_full) < MAX_NODES);
      meta_in.face    = n_face;
      meta_in.open_nb = n_grid && ((n_face == FACE_NONE) || neumann_ff[n_face]);

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            step_in    = STEP_CENTER;
            edge_in    = 1'b0;
            if (req_acc && req_tuser == OP_READ) begin
               if (req_ok) begin
                  state_in = ST_RUN;
               end else begin
                  res_class_in = '0;
                  res_err_in   = 1'b1;
                  state_in     = ST_FINISH;
               end
            end
         end
         ST_RUN: begin
            step_in = step_ff + 1'b1;
            // data of the previous step is on the memory output
            if (step_ff == STEP_XM) begin
               center_in = lab_now;
               cface_in  = meta_ff.face;
            end else if (step_ff != STEP_CENTER) begin
               edge_in = edge_all;
            end
            if (step_ff == STEP_LAST) begin
               res_err_in = 1'b0;
               if (center_ff == '0) begin
                  if (cface_ff == FACE_NONE) begin
                     res_class_in = '0;
                  end else if (neumann_ff[cface_ff]) begin
                     res_class_in = CLASS_W'(-(CLASS_W'(cface_ff) + 1'b1));
                  end else begin
                     res_class_in = CLASS_W'(cface_ff) + 1'b1;
                  end
               end else if (center_ff >= SOLID_MIN && edge_all) begin
                  res_class_in = CLASS_W'(-CLASS_W'(center_ff));
               end else begin
                  res_class_in = CLASS_W'(center_ff);
               end
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_tready);
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= STEP_CENTER;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_acc) begin
         cx_ff <= req_x;
         cy_ff <= req_y;
         cz_ff <= req_z;
      end
      meta_ff      <= meta_in;
      center_ff    <= center_in;
      cface_ff     <= cface_in;
      edge_ff      <= edge_in;
      res_class_ff <= res_class_in;
      res_err_ff   <= res_err_in;
      if (rsp_load) begin
         rsp_class_ff <= res_class_ff;
         rsp_err_ff   <= res_err_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_class_ff;
   assign rsp_tuser  = rsp_err_ff;

endmodule

`default_nettype wire

### sim/tb_grid_boundary_edge_marker.sv
`timescale 1ns / 1ps

module tb_grid_boundary_edge_marker;
   import gbem_pkg::*;

   localparam int GRID_DIM      = 16;
   localparam int GRID_NODES    = 4096;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int DRAIN_LIMIT   = 20000;
   localparam int SETTLE_CYCLES = 16;
   localparam int HOLD_LEN      = 400;
   localparam int PHASES        = 16;
   localparam int FOCUS_SPAN    = 4;

   // mode code 3 behaves as 3D; index 7 holds no register
   localparam logic [MODE_W-1:0]    MODE_ALT_3D = 2'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE   = 3'd7;

   // Mirror of the label grid; predicts the class of every read request
   class node_class_scoreboard;
      typedef struct packed {
         logic [CLASS_W-1:0] node_class;
         logic               position_error;
      } node_result_type;

      logic [LABEL_W-1:0] labels [GRID_NODES];
      bit                 written [GRID_NODES];
      int                 extent [3];
      logic [MODE_W-1:0]  mode;
      logic [FACES-1:0]   neumann;
      node_result_type    expected_classes [$];
      int                 errors;
      int                 reads_checked;
      int                 edge_solids;
      int                 face_marks;
      int                 range_errors;

      function new();
         for (int d = 0; d < 3; d++) extent[d] = GRID_DIM;
         mode    = MODE_RST;
         neumann = NEUMANN_RST;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
         int clipped;
         clipped = int'(data[SIZE_W-1:0]);
         if (clipped > GRID_DIM) clipped = GRID_DIM;
         case (index)
            REG_SIZE_X:  extent[0] = clipped;
            REG_SIZE_Y:  extent[1] = clipped;
            REG_SIZE_Z:  extent[2] = clipped;
            REG_MODE:    mode = data[MODE_W-1:0];
            REG_NEUMANN: neumann = data[FACES-1:0];
            default: ;
         endcase
      endfunction

      function bit in_grid(int x, int y, int z);
         return x >= 0 && x < extent[0] && y >= 0 && y < extent[1] && z >= 0 && z < extent[2];
      endfunction

      function int node_index(int x, int y, int z);
         return (z * GRID_DIM + y) * GRID_DIM + x;
      endfunction

      // first active face in priority order
      function logic [FACE_W-1:0] first_face(int x, int y, int z);
         if (x == 0) return FACE_XMIN;
         if (x == extent[0] - 1) return FACE_XMAX;
         if (mode >= MODE_2D) begin
            if (y == 0) return FACE_YMIN;
            if (y == extent[1] - 1) return FACE_YMAX;
         end
         if (mode >= MODE_3D) begin
            if (z == 0) return FACE_ZMIN;
            if (z == extent[2] - 1) return FACE_ZMAX;
         end
         return FACE_NONE;
      endfunction

      // vacuum neighbor that is unmarked or carries a Neumann mark
      function bit open_neighbor(int x, int y, int z);
         logic [FACE_W-1:0] f;
         if (!in_grid(x, y, z)) return 1'b0;
         if (labels[node_index(x, y, z)] != '0) return 1'b0;
         f = first_face(x, y, z);
         return f == FACE_NONE || neumann[f];
      endfunction

      function logic [CLASS_W-1:0] classify_node(int x, int y, int z);
         logic [LABEL_W-1:0] raw;
         logic [FACE_W-1:0]  f;
         int                 mark;
         bit                 edge_found;
         raw = labels[node_index(x, y, z)];
         if (raw == '0) begin
            f = first_face(x, y, z);
            if (f == FACE_NONE) return '0;
            face_marks++;
            mark = int'(f) + 1;
            return neumann[f] ? CLASS_W'(-mark) : CLASS_W'(mark);
         end
         edge_found = raw >= SOLID_MIN &&
                      (open_neighbor(x - 1, y, z) || open_neighbor(x + 1, y, z) ||
                       open_neighbor(x, y - 1, z) || open_neighbor(x, y + 1, z) ||
                       open_neighbor(x, y, z - 1) || open_neighbor(x, y, z + 1));
         if (edge_found) begin
            edge_solids++;
            return CLASS_W'(-int'(raw));
         end
         return CLASS_W'(raw);
      endfunction

      // node or in-grid neighbor that was never written, if any
      function bit first_unwritten(int x, int y, int z, output int mx, output int my,
                                   output int mz);
         int offs [7][3];
         offs = '{'{0, 0, 0}, '{-1, 0, 0}, '{1, 0, 0}, '{0, -1, 0}, '{0, 1, 0},
                  '{0, 0, -1}, '{0, 0, 1}};
         for (int k = 0; k < 7; k++) begin
            mx = x + offs[k][0];
            my = y + offs[k][1];
            mz = z + offs[k][2];
            if (in_grid(mx, my, mz) && !written[node_index(mx, my, mz)]) return 1'b1;
         end
         return 1'b0;
      endfunction

      function void note_request(logic op, int x, int y, int z, logic [LABEL_W-1:0] label);
         node_result_type r;
         if (op == OP_WRITE) begin
            // writes outside the grid in use are dropped
            if (in_grid(x, y, z)) begin
               labels[node_index(x, y, z)]  = label;
               written[node_index(x, y, z)] = 1'b1;
            end
            return;
         end
         if (!in_grid(x, y, z)) begin
            r.node_class     = '0;
            r.position_error = 1'b1;
            range_errors++;
         end else begin
            r.node_class     = classify_node(x, y, z);
            r.position_error = 1'b0;
         end
         expected_classes = {expected_classes, r};
      endfunction

      function void check_response(logic [CLASS_W-1:0] node_class, logic position_error);
         node_result_type want;
         if (expected_classes.size() == 0) begin
            $error("response with no read outstanding: node_class %0d position_error %0b",
                   $signed(node_class), position_error);
            errors++;
            return;
         end
         want = expected_classes.pop_front();
         reads_checked++;
         if (node_class !== want.node_class) begin
            $error("node_class: expected %0d, actual %0d", $signed(want.node_class),
                   $signed(node_class));
            errors++;
         end
         if (position_error !== want.position_error) begin
            $error("position_error: expected %0b, actual %0b", want.position_error,
                   position_error);
            errors++;
         end
      endfunction
   endclass

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [23:0]           req_tdata  = '0;   // x_pos, y_pos, z_pos, raw_label
   logic                  req_tuser  = 1'b0; // op
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [7:0]            rsp_tdata;         // node_class
   logic                  rsp_tuser;         // position_error
   logic                  csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   int  idle_pct      = 0;
   int  stall_pct     = 0;
   bit  long_hold     = 1'b0;
   int  held_cycles   = 0;
   int  cycle_count   = 0;
   int  requests_sent = 0;
   int  org [3];
   int  span [3];
   node_class_scoreboard node_board;

   grid_boundary_edge_marker i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $error("run exceeded %0d cycles", CYCLE_LIMIT);
         $display("** grid_boundary_edge_marker: FAILED **");
         $finish;
      end
   end

   // receiver: random stalls, plus one long hold-off counted here
   always @(negedge clock) begin
      if (long_hold && held_cycles < HOLD_LEN) begin
         held_cycles <= held_cycles + 1;
         rsp_tready  <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // response check
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         node_board.check_response(rsp_tdata, rsp_tuser);
   end

   // one request, after a random gap; returns once it is accepted
   task automatic send_request(input logic op, input int x, input int y, input int z,
                               input logic [LABEL_W-1:0] label);
      while ($urandom_range(0, 99) < idle_pct) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {5'b0, label, 4'(z), 4'(y), 4'(x)};
      do @(posedge clock); while (!req_tready);
      node_board.note_request(op, x, y, z, label);
      requests_sent++;
   endtask

   // stop sending and let every outstanding read come back
   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      for (int w = 0; w < DRAIN_LIMIT && node_board.expected_classes.size() != 0; w++)
         @(posedge clock);
      if (node_board.expected_classes.size() != 0) begin
         $error("%0d read responses never arrived", node_board.expected_classes.size());
         node_board.errors++;
         node_board.expected_classes.delete();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // all registers, unused upper data bits randomized
   task automatic apply_setting(input logic [SIZE_W-1:0] sx, input logic [SIZE_W-1:0] sy,
                                input logic [SIZE_W-1:0] sz, input logic [MODE_W-1:0] mode,
                                input logic [FACES-1:0] faces);
      logic [CSR_IDX_W-1:0]  idx [6];
      logic [CSR_DATA_W-1:0] val [6];
      idx = '{REG_SIZE_X, REG_SIZE_Y, REG_SIZE_Z, REG_MODE, REG_SPARE, REG_NEUMANN};
      val[0] = {(CSR_DATA_W - SIZE_W)'($urandom), sx};
      val[1] = {(CSR_DATA_W - SIZE_W)'($urandom), sy};
      val[2] = {(CSR_DATA_W - SIZE_W)'($urandom), sz};
      val[3] = {(CSR_DATA_W - MODE_W)'($urandom), mode};
      val[4] = CSR_DATA_W'($urandom);
      val[5] = faces;
      for (int k = 0; k < 6; k++) begin
         @(negedge clock);
         csr_we    <= 1'b1;
         csr_index <= idx[k];
         csr_wdata <= val[k];
         @(posedge clock);
         node_board.set_register(idx[k], val[k]);
      end
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic logic [LABEL_W-1:0] pick_label();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return '0;
      if (r < 55) return LABEL_W'($urandom_range(1, 6));
      return LABEL_W'($urandom_range(int'(SOLID_MIN), 127));
   endfunction

   // mostly reads and writes in a small box, some noise over the full range;
   // a read that would touch an unwritten node writes that node instead
   task automatic random_item();
      int                 x, y, z, mx, my, mz;
      logic               op;
      logic [LABEL_W-1:0] label;
      if ($urandom_range(0, 99) >= 8 && span[0] > 0 && span[1] > 0 && span[2] > 0) begin
         x  = org[0] + $urandom_range(0, span[0] - 1);
         y  = org[1] + $urandom_range(0, span[1] - 1);
         z  = org[2] + $urandom_range(0, span[2] - 1);
         op = ($urandom_range(0, 99) < 55) ? OP_READ : OP_WRITE;
      end else begin
         x  = $urandom_range(0, GRID_DIM - 1);
         y  = $urandom_range(0, GRID_DIM - 1);
         z  = $urandom_range(0, GRID_DIM - 1);
         op = $urandom_range(0, 1) ? OP_READ : OP_WRITE;
      end
      label = pick_label();
      if (op == OP_READ && node_board.first_unwritten(x, y, z, mx, my, mz)) begin
         op = OP_WRITE;
         x  = mx;
         y  = my;
         z  = mz;
      end
      send_request(op, x, y, z, label);
   endtask

   initial begin
      logic [LABEL_W-1:0] corner_labels [8];
      int                 items;
      int                 ext;

      node_board = new();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: a 2x2x2 grid, Neumann on the min faces only
      apply_setting(5'd2, 5'd2, 5'd2, MODE_3D, 6'b010101);
      corner_labels = '{7'd0, 7'd127, 7'd7, 7'd0, 7'd3, 7'd0, 7'd6, 7'd1};
      for (int n = 0; n < 8; n++)
         send_request(OP_WRITE, n & 1, (n >> 1) & 1, (n >> 2) & 1, corner_labels[n]);
      // writes outside the grid are dropped, reads there flag a position error
      send_request(OP_WRITE, 15, 15, 15, 7'd127);
      send_request(OP_WRITE, 2, 0, 0, 7'd0);
      send_request(OP_READ, 15, 15, 15, 7'd0);
      send_request(OP_READ, 0, 2, 1, 7'd127);
      for (int n = 0; n < 8; n++)
         send_request(OP_READ, n & 1, (n >> 1) & 1, (n >> 2) & 1, 7'd0);
      wait_idle();

      // random phases over a spread of grid settings and idle patterns
      for (int p = 1; p < PHASES; p++) begin
         items = 136;
         case (p)
            1:  apply_setting(5'd4, 5'd4, 5'd4, MODE_3D, 6'($urandom));
            2:  apply_setting(5'd16, 5'd16, 5'd16, MODE_3D, 6'd0);
            3:  apply_setting(5'd1, 5'd1, 5'd1, MODE_ALT_3D, 6'h3f);
            4:  apply_setting(5'd5, 5'd3, 5'd1, MODE_2D, 6'($urandom));
            5: begin
               // a zero size puts every position out of range
               apply_setting(5'd0, 5'd4, 5'd4, MODE_3D, 6'($urandom));
               items = 30;
            end
            6:  apply_setting(5'd31, 5'd20, 5'd17, MODE_3D, 6'h3f);
            7:  apply_setting(5'd16, 5'd1, 5'd1, MODE_1D, 6'($urandom));
            8:  apply_setting(5'd3, 5'd16, 5'd2, MODE_2D, 6'($urandom));
            9:  apply_setting(5'd6, 5'd6, 5'd6, MODE_ALT_3D, 6'($urandom));
            10: apply_setting(5'd2, 5'd7, 5'd3, MODE_1D, 6'($urandom));
            default: apply_setting(5'($urandom_range(1, 8)), 5'($urandom_range(1, 8)),
                                   5'($urandom_range(1, 8)), 2'($urandom),
                                   6'($urandom));
         endcase

         case (p % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 63; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 63; end
            default: begin idle_pct = 36; stall_pct = 36; end
         endcase

         // small working box, often against the grid faces
         for (int d = 0; d < 3; d++) begin
            ext     = node_board.extent[d];
            span[d] = ext < FOCUS_SPAN ? ext : FOCUS_SPAN;
            case ($urandom_range(0, 2))
               0: org[d] = 0;
               1: org[d] = ext - span[d];
               default: org[d] = $urandom_range(0, ext - span[d]);
            endcase
         end

         // receiver backs off long enough for the block to stall its input
         if (p == 4) long_hold = 1'b1;

         for (int i = 0; i < items; i++) begin
            if (p % 3 == 2 && i == items / 2) wait_idle();
            random_item();
         end
         wait_idle();
      end

      $display("Checked %0d read responses: %0d solid edges, %0d face marks, %0d out of range",
               node_board.reads_checked, node_board.edge_solids, node_board.face_marks,
               node_board.range_errors);
      $display("%0d requests over %0d grid settings, with sender gaps, receiver stalls "
               , requests_sent, PHASES, "and one long receiver hold-off");
      if (node_board.errors == 0) begin
         $display("** grid_boundary_edge_marker: PASSED **");
      end else begin
         $display("** grid_boundary_edge_marker: FAILED **");
      end
      $finish;
   end

endmodule

### sim.f
design/gbem_pkg.sv
design/gbem_label_ram.sv
design/grid_boundary_edge_marker.sv
sim/tb_grid_boundary_edge_marker.sv
